// ----- rtl/core/radix2_dit_fft_macros.svh -----
// Assertion macros used by the checker file.
`ifndef RADIX2_DIT_FFT_MACROS_SVH
`define RADIX2_DIT_FFT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define R2F_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define R2F_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/r2f_pkg.sv -----
package r2f_pkg;
  localparam int unsigned ValW = 23;
  localparam int unsigned SmpW = 16;
  localparam int unsigned TwW = 19;
  localparam int unsigned IdxW = 6;
  localparam int unsigned KW = 3;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [TwW-1:0] tw_t;

  typedef enum logic [0:0] {
    CFG_LOG2_POINTS = 1'b0,
    CFG_INVERSE_MODE = 1'b1
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_sample;
    logic [IdxW-1:0]   wr_addr;
    logic              rd_en;
    logic [IdxW-1:0]   rd_addr;
    logic              lat_a;
    logic              lat_b;
    logic              mul;
    logic              bfly_wr_p;
    logic              bfly_wr_q;
    logic              swap_wr_a;
    logic              swap_wr_b;
    logic [IdxW-1:0]   p_addr;
    logic [IdxW-1:0]   q_addr;
    logic [4:0]        tw_j;
    logic              inv;
    logic              out_load;
    logic [IdxW-1:0]   out_index;
    logic              out_last;
  } r2f_cmd_t;

  typedef struct packed {
    logic out_busy;
  } r2f_sts_t;

  localparam logic [17:0] QuarterCos [17] = '{
    18'd131072, 18'd130441, 18'd128553, 18'd125428, 18'd121095, 18'd115595,
    18'd108982, 18'd101320, 18'd92682, 18'd83151, 18'd72820, 18'd61787,
    18'd50159, 18'd38048, 18'd25571, 18'd12847, 18'd0
  };

  function automatic tw_t cos_j(input logic [4:0] j);
    logic [4:0] jj;
    jj = 5'd0;
    if (j <= 5'd16) begin
      return tw_t'(signed'({1'b0, QuarterCos[j]}));
    end
    jj = 5'(6'd32 - {1'b0, j});
    return -tw_t'(signed'({1'b0, QuarterCos[jj]}));
  endfunction

  function automatic tw_t sin_j(input logic [4:0] j);
    logic [4:0] jj;
    jj = 5'd0;
    if (j <= 5'd16) begin
      jj = 5'(5'd16 - j);
      return tw_t'(signed'({1'b0, QuarterCos[jj]}));
    end
    jj = 5'(j - 5'd16);
    return tw_t'(signed'({1'b0, QuarterCos[jj]}));
  endfunction
endpackage

// ----- rtl/core/r2f_stream_if.sv -----
interface r2f_stream_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/r2f_datapath.sv -----
module r2f_datapath
  import r2f_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  r2f_cmd_t    cmd,
  input  logic signed [SmpW-1:0] smp_re,
  input  logic signed [SmpW-1:0] smp_im,
  input  logic        out_ready,
  output r2f_sts_t    sts,
  output logic        out_valid,
  output val_t        out_re,
  output val_t        out_im,
  output logic [IdxW-1:0] out_index,
  output logic        out_last
);
  val_t mem_re [64];
  val_t mem_im [64];
  val_t rd_re_r, rd_im_r;
  val_t a_re_r, a_im_r, b_re_r, b_im_r;
  logic signed [41:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  tw_t wr, wi;
  logic signed [42:0] sre, sim;
  val_t t_re, t_im;
  logic out_valid_r, out_valid_nxt;
  logic out_pend_r, out_pend_nxt;
  logic [IdxW-1:0] oidx_r, oidx_pend_r;
  logic olast_r, olast_pend_r;

  always_comb begin
    wr = cos_j(cmd.tw_j);
    wi = cmd.inv ? sin_j(cmd.tw_j) : -sin_j(cmd.tw_j);
    sre = 43'(p_rr_r) - 43'(p_ii_r) + 43'sd65536;
    sim = 43'(p_ri_r) + 43'(p_ir_r) + 43'sd65536;
    t_re = val_t'(sre >>> 17);
    t_im = val_t'(sim >>> 17);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      mem_re[cmd.wr_addr] <= val_t'(smp_re);
      mem_im[cmd.wr_addr] <= val_t'(smp_im);
    end else if (cmd.bfly_wr_p) begin
      mem_re[cmd.p_addr] <= a_re_r + t_re;
      mem_im[cmd.p_addr] <= a_im_r + t_im;
    end else if (cmd.bfly_wr_q) begin
      mem_re[cmd.q_addr] <= a_re_r - t_re;
      mem_im[cmd.q_addr] <= a_im_r - t_im;
    end else if (cmd.swap_wr_a) begin
      mem_re[cmd.p_addr] <= b_re_r;
      mem_im[cmd.p_addr] <= b_im_r;
    end else if (cmd.swap_wr_b) begin
      mem_re[cmd.q_addr] <= a_re_r;
      mem_im[cmd.q_addr] <= a_im_r;
    end
    if (cmd.rd_en) begin
      rd_re_r <= mem_re[cmd.rd_addr];
      rd_im_r <= mem_im[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      a_re_r <= rd_re_r;
      a_im_r <= rd_im_r;
    end
    if (cmd.lat_b) begin
      b_re_r <= rd_re_r;
      b_im_r <= rd_im_r;
    end
    if (cmd.mul) begin
      p_rr_r <= b_re_r * wr;
      p_ii_r <= b_im_r * wi;
      p_ri_r <= b_re_r * wi;
      p_ir_r <= b_im_r * wr;
    end
  end

  // Output register plus one pending stage; out_load carries the read beat.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pend_nxt = out_pend_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = out_pend_r;
      out_pend_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      if (out_valid_nxt) begin
        out_pend_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_pend_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_pend_r <= out_pend_nxt;
    end
  end

  val_t ore_r, oim_r, pre_r, pim_r;
  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready && out_pend_r) begin
      ore_r <= pre_r;
      oim_r <= pim_r;
      oidx_r <= oidx_pend_r;
      olast_r <= olast_pend_r;
    end
    if (cmd.out_load) begin
      if (out_valid_r && !(out_ready && !out_pend_r)) begin
        pre_r <= rd_re_r;
        pim_r <= rd_im_r;
        oidx_pend_r <= cmd.out_index;
        olast_pend_r <= cmd.out_last;
      end else if (!out_valid_r || (out_ready && !out_pend_r)) begin
        ore_r <= rd_re_r;
        oim_r <= rd_im_r;
        oidx_r <= cmd.out_index;
        olast_r <= cmd.out_last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_re = ore_r;
  assign out_im = oim_r;
  assign out_index = oidx_r;
  assign out_last = olast_r;
  assign sts.out_busy = out_pend_r || (out_valid_r && !out_ready);
endmodule

// ----- rtl/core/r2f_ctrl.sv -----
module r2f_ctrl
  import r2f_pkg::*;
#(
  parameter int unsigned MAX_LOG2_POINTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [KW-1:0] log2_points,
  input  logic        inverse_mode,
  input  r2f_sts_t    sts,
  output r2f_cmd_t    cmd
);
  typedef enum logic [3:0] {
    S_LOAD, S_REV_RA, S_REV_RB, S_REV_LA, S_REV_LB, S_REV_W,
    S_BF_RB, S_BF_RA, S_BF_LB, S_BF_LA, S_BF_MUL, S_BF_WP, S_BF_WQ,
    S_OUT_RD, S_OUT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic [IdxW:0] cnt_r, cnt_nxt;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] stage_r, stage_nxt;
  logic [IdxW-1:0] m_r, m_nxt, i_r, i_nxt;
  logic [IdxW:0] n_full;
  logic [IdxW-1:0] l_span, rev_a, p_a, q_a;

  always_comb begin
    k_eff = log2_points;
    if (k_eff < KW'(1)) k_eff = KW'(1);
    if (k_eff > KW'(MAX_LOG2_POINTS)) k_eff = KW'(MAX_LOG2_POINTS);
    n_full = (IdxW+1)'(1) << k_eff;
    l_span = IdxW'(1) << stage_r;
    rev_a = '0;
    for (int b = 0; b < IdxW; b++) begin
      if (b < int'(k_eff)) rev_a[int'(k_eff) - 1 - b] = i_r[b];
    end
    p_a = i_r;
    q_a = i_r + l_span;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    stage_nxt = stage_r;
    m_nxt = m_r;
    i_nxt = i_r;
    cmd = '0;
    cmd.inv = inverse_mode;
    cmd.wr_addr = cnt_r[IdxW-1:0];
    cmd.tw_j = 5'(m_r << (3'd5 - stage_r));
    cmd.p_addr = p_a;
    cmd.q_addr = q_a;
    in_ready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_sample = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r + 1'b1 >= n_full) begin
            i_nxt = '0;
            state_nxt = S_REV_RA;
          end
        end
      end
      S_REV_RA: begin
        if (rev_a > i_r) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = i_r;
          state_nxt = S_REV_RB;
        end else if ((IdxW+1)'(i_r) + 1'b1 >= n_full) begin
          stage_nxt = '0; m_nxt = '0; i_nxt = '0;
          state_nxt = S_BF_RB;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_REV_RB: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = rev_a; cmd.lat_a = 1'b1;
        state_nxt = S_REV_LB;
      end
      S_REV_LB: begin
        cmd.lat_b = 1'b1; state_nxt = S_REV_W;
      end
      S_REV_W: begin
        cmd.swap_wr_a = 1'b1; cmd.p_addr = i_r;
        state_nxt = S_REV_LA;
      end
      S_REV_LA: begin
        cmd.swap_wr_b = 1'b1; cmd.q_addr = rev_a;
        if ((IdxW+1)'(i_r) + 1'b1 >= n_full) begin
          stage_nxt = '0; m_nxt = '0; i_nxt = '0;
          state_nxt = S_BF_RB;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_REV_RA;
        end
      end
      S_BF_RB: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = q_a; state_nxt = S_BF_RA;
      end
      S_BF_RA: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = p_a; cmd.lat_b = 1'b1;
        state_nxt = S_BF_LA;
      end
      S_BF_LA: begin
        cmd.lat_a = 1'b1; cmd.mul = 1'b1; state_nxt = S_BF_WP;
      end
      S_BF_WP: begin
        cmd.bfly_wr_p = 1'b1; state_nxt = S_BF_WQ;
      end
      S_BF_WQ: begin
        cmd.bfly_wr_q = 1'b1;
        state_nxt = S_BF_RB;
        if ((IdxW+1)'(i_r) + (IdxW+1)'(l_span) * (IdxW+1)'(3) < n_full) begin
          i_nxt = i_r + (l_span << 1);
        end else if ((IdxW+1)'(m_r) + 1'b1 < (IdxW+1)'(l_span)) begin
          m_nxt = m_r + 1'b1; i_nxt = m_r + 1'b1;
        end else if (stage_r + 1'b1 < k_eff) begin
          stage_nxt = stage_r + 1'b1; m_nxt = '0; i_nxt = '0;
        end else begin
          i_nxt = '0; state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        if (!sts.out_busy) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = i_r; state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_index = i_r;
        cmd.out_last = ((IdxW+1)'(i_r) + 1'b1 >= n_full);
        if (cmd.out_last) begin
          cnt_nxt = '0; state_nxt = S_LOAD;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = S_OUT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      stage_r <= '0;
      m_r <= '0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      stage_r <= stage_nxt;
      m_r <= m_nxt;
      i_r <= i_nxt;
    end
  end
endmodule

// ----- rtl/core/radix2_dit_fft.sv -----
// Channel  Dir  Payload
// in       in   sample_re[15:0], sample_im[15:0]  (data = {im, re})
// out      out  bin_re[22:0], bin_im[22:0], bin_index[5:0], last_bin
//               (data = {last, index, im, re})
// cfg      in   index[0], data[2:0]; 0 log2_points, 1 inverse_mode
// Each sample is written to the store in the cycle it is accepted. After
// the last sample of a frame the one shared butterfly runs: bit reversal
// swaps each pair, each butterfly reads and writes back both points, and
// each bin is read out, all through the store's single read and write port.
// Reset is synchronous, active low. Output stalls pause the read-out only.
module radix2_dit_fft
  import r2f_pkg::*;
#(
  parameter int unsigned MAX_LOG2_POINTS = 6
) (
  input  logic clk,
  input  logic rst_n,
  r2f_stream_if.sink   in_s,
  r2f_stream_if.source out_s,
  r2f_stream_if.sink   cfg_s
);
  logic [KW-1:0] log2_points_r;
  logic inverse_mode_r;
  r2f_cmd_t cmd;
  r2f_sts_t sts;
  val_t ore, oim;
  logic [IdxW-1:0] oidx;
  logic olast;

  assign cfg_s.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_points_r <= KW'(6);
      inverse_mode_r <= 1'b0;
    end else if (cfg_s.valid) begin
      case (cfg_idx_t'(cfg_s.data[KW]))
        CFG_LOG2_POINTS: log2_points_r <= cfg_s.data[KW-1:0];
        CFG_INVERSE_MODE: inverse_mode_r <= cfg_s.data[0];
        default: ;
      endcase
    end
  end

  r2f_ctrl #(.MAX_LOG2_POINTS(MAX_LOG2_POINTS)) u_ctrl (
    .clk, .rst_n, .in_valid(in_s.valid), .in_ready(in_s.ready),
    .log2_points(log2_points_r), .inverse_mode(inverse_mode_r), .sts, .cmd
  );

  r2f_datapath u_dp (
    .clk, .rst_n, .cmd,
    .smp_re(in_s.data[15:0]), .smp_im(in_s.data[31:16]),
    .out_ready(out_s.ready), .sts, .out_valid(out_s.valid),
    .out_re(ore), .out_im(oim), .out_index(oidx), .out_last(olast)
  );

  assign out_s.data = {olast, oidx, oim, ore};
endmodule

// ----- rtl/core/r2f_checker.sv -----
`include "radix2_dit_fft_macros.svh"
module r2f_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [52:0] out_data
);
  `R2F_ASSERT_IMP(a_out_known, clk, rst_n, out_valid, !$isunknown(out_data))
  `R2F_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `R2F_ASSERT_NXT(a_first_after_last, clk, rst_n, out_valid && out_ready && out_data[52], !out_valid || out_data[51:46] == 6'd0)
endmodule

bind radix2_dit_fft r2f_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);

// ----- sim/tb.sv -----
module tb;
  import r2f_pkg::*;

  localparam int unsigned RandomSamples = 310;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 20;

  typedef struct packed {
    logic       last;
    logic [5:0] index;
    val_t       im;
    val_t       re;
  } bin_t;

  typedef struct {
    bit is_cfg;
    int a;
    int b;
    bit typed;
    int e0r;
    int e0i;
    int e1r;
    int e1i;
  } stim_row_t;

  localparam longint QuarterWave [17] = '{
    131072, 130441, 128553, 125428, 121095, 115595, 108982, 101320,
    92682, 83151, 72820, 61787, 50159, 38048, 25571, 12847, 0
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  r2f_stream_if #(.W(32)) in_s ();
  r2f_stream_if #(.W(53)) out_s ();
  r2f_stream_if #(.W(4))  cfg_s ();

  radix2_dit_fft dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s),
    .cfg_s (cfg_s)
  );

  // Predictor state: a private copy of the sample store and registers.
  longint      store_re [64];
  longint      store_im [64];
  int unsigned held;
  logic [2:0]  size_reg;
  logic        inv_reg;
  bin_t        bins_due [$];
  int unsigned errors;
  bit          calm;
  int unsigned out_stall;
  int unsigned idle_cycles;

  function automatic longint wrap23(longint v);
    val_t t;
    t = v[22:0];
    return longint'(t);
  endfunction

  function automatic longint tw_cos(int unsigned j);
    j = j & 31;
    if (j <= 16) begin
      return QuarterWave[j];
    end
    return -QuarterWave[32 - j];
  endfunction

  function automatic longint tw_sin(int unsigned j);
    j = j & 31;
    if (j <= 16) begin
      return QuarterWave[16 - j];
    end
    return QuarterWave[j - 16];
  endfunction

  function automatic void transform_store(int unsigned k, bit inv);
    int unsigned n;
    int unsigned r;
    int unsigned l;
    int unsigned q;
    longint wr, wi, br, bi, tr, ti, ar, ai, sw;
    n = 1 << k;
    for (int unsigned a = 0; a < n; a++) begin
      r = 0;
      for (int unsigned b = 0; b < k; b++) begin
        r |= ((a >> b) & 1) << (k - 1 - b);
      end
      if (r > a) begin
        sw = store_re[a]; store_re[a] = store_re[r]; store_re[r] = sw;
        sw = store_im[a]; store_im[a] = store_im[r]; store_im[r] = sw;
      end
    end
    for (int unsigned s = 0; s < k; s++) begin
      l = 1 << s;
      for (int unsigned m = 0; m < l; m++) begin
        wr = tw_cos(m << (5 - s));
        wi = inv ? tw_sin(m << (5 - s)) : -tw_sin(m << (5 - s));
        for (int unsigned i = m; i + l < n; i += 2 * l) begin
          q = i + l;
          br = store_re[q];
          bi = store_im[q];
          // Round to nearest with ties upwards: floor((x + 2^16) / 2^17).
          tr = (br * wr - bi * wi + 65536) >>> 17;
          ti = (br * wi + bi * wr + 65536) >>> 17;
          ar = store_re[i];
          ai = store_im[i];
          store_re[q] = wrap23(ar - tr);
          store_im[q] = wrap23(ai - ti);
          store_re[i] = wrap23(ar + tr);
          store_im[i] = wrap23(ai + ti);
        end
      end
    end
  endfunction

  // Returns 1 when the sample completed a frame.
  function automatic bit absorb_sample(logic [15:0] re, logic [15:0] im, bit typed);
    int unsigned k;
    int unsigned n;
    bin_t b;
    k = (size_reg < 1) ? 1 : ((size_reg > 6) ? 6 : size_reg);
    n = 1 << k;
    store_re[held & 63] = longint'($signed(re));
    store_im[held & 63] = longint'($signed(im));
    held = (held + 1) & 127;
    if (held < n) begin
      return 1'b0;
    end
    transform_store(k, inv_reg);
    if (!typed) begin
      for (int unsigned i = 0; i < n; i++) begin
        b.re = store_re[i][22:0];
        b.im = store_im[i][22:0];
        b.index = i[5:0];
        b.last = (i == n - 1);
        bins_due.push_back(b);
      end
    end
    held = 0;
    return 1'b1;
  endfunction

  task automatic wait_gap();
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_sample(logic [15:0] re, logic [15:0] im, bit typed = 1'b0);
    wait_gap();
    in_s.valid <= 1'b1;
    in_s.data <= {im, re};
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    void'(absorb_sample(re, im, typed));
  endtask

  task automatic wait_drained();
    while (bins_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [2:0] value);
    in_s.valid <= 1'b0;
    wait_drained();
    cfg_s.valid <= 1'b1;
    cfg_s.data <= {idx, value};
    @(posedge clk);
    while (!cfg_s.ready) @(posedge clk);
    cfg_s.valid <= 1'b0;
    if (idx == CFG_LOG2_POINTS) begin
      size_reg = value;
    end else begin
      inv_reg = value[0];
    end
  endtask

  function automatic logic [15:0] draw_part();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    bin_t got;
    bin_t want;
    int unsigned stall_draw;
    if (!rst_n) begin
      out_s.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_s.valid && out_s.ready) begin
      got = out_s.data;
      if (bins_due.size() == 0) begin
        $error("bin beat with nothing due: index %0d", got.index);
        errors++;
      end else begin
        want = bins_due.pop_front();
        if (got.re !== want.re) begin
          $error("bin_re: expected %0d, got %0d", want.re, got.re);
          errors++;
        end
        if (got.im !== want.im) begin
          $error("bin_im: expected %0d, got %0d", want.im, got.im);
          errors++;
        end
        if (got.index !== want.index) begin
          $error("bin_index: expected %0d, got %0d", want.index, got.index);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last_bin: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
      stall_draw = calm ? 0 : $urandom_range(0, 4);
      out_stall <= stall_draw;
      out_s.ready <= (stall_draw == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_s.ready <= (out_stall == 1);
    end else begin
      out_s.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_s.valid && in_s.ready) || (out_s.valid && out_s.ready) ||
        (cfg_s.valid && cfg_s.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows [$];
    int unsigned sent;
    int unsigned n;
    int unsigned frames;
    int unsigned pick;
    logic [2:0] k_draw;
    bin_t b;

    in_s.valid = 1'b0;
    in_s.data = '0;
    cfg_s.valid = 1'b0;
    cfg_s.data = '0;
    errors = 0;
    calm = 1'b0;
    held = 0;
    size_reg = 3'd6;
    inv_reg = 1'b0;
    idle_cycles = 0;
    foreach (store_re[i]) begin
      store_re[i] = 0;
      store_im[i] = 0;
    end

    rows = '{
      '{1, CFG_LOG2_POINTS, 1, 0, 0, 0, 0, 0},
      '{1, CFG_INVERSE_MODE, 0, 0, 0, 0, 0, 0},
      '{0, 32767, -32768, 0, 0, 0, 0, 0},
      '{0, 32767, -32768, 1, 65534, -65536, 0, 0},
      '{0, -32768, 32767, 0, 0, 0, 0, 0},
      '{0, 32767, -32768, 1, -1, -1, -65535, 65535},
      '{1, CFG_INVERSE_MODE, 1, 0, 0, 0, 0, 0},
      '{0, 1, 2, 0, 0, 0, 0, 0},
      '{0, 3, 4, 1, 4, 6, -2, -2},
      // A size of zero behaves as two points.
      '{1, CFG_LOG2_POINTS, 0, 0, 0, 0, 0, 0},
      '{0, 5, 0, 0, 0, 0, 0, 0},
      '{0, 0, 5, 1, 5, 5, 5, -5},
      '{1, CFG_LOG2_POINTS, 2, 0, 0, 0, 0, 0},
      '{1, CFG_INVERSE_MODE, 0, 0, 0, 0, 0, 0},
      '{0, -32768, -32768, 0, 0, 0, 0, 0},
      '{0, 32767, 32767, 0, 0, 0, 0, 0},
      '{0, -32768, 32767, 0, 0, 0, 0, 0},
      '{0, 32767, -32768, 0, 0, 0, 0, 0},
      // Shrinking the size mid-frame: the next sample completes the frame.
      '{0, 1234, -4321, 0, 0, 0, 0, 0},
      '{0, -7, 99, 0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 0, 0},
      '{1, CFG_LOG2_POINTS, 1, 0, 0, 0, 0, 0},
      '{0, -100, 200, 0, 0, 0, 0, 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        write_reg(cfg_idx_t'(rows[r].a), rows[r].b[2:0]);
      end else begin
        push_sample(rows[r].a[15:0], rows[r].b[15:0], rows[r].typed);
        if (rows[r].typed) begin
          b = '{1'b0, 6'd0, val_t'(rows[r].e0i), val_t'(rows[r].e0r)};
          bins_due.push_back(b);
          b = '{1'b1, 6'd1, val_t'(rows[r].e1i), val_t'(rows[r].e1r)};
          bins_due.push_back(b);
        end
      end
    end

    sent = 0;
    while (sent < RandomSamples) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: k_draw = 3'd0;
        1: k_draw = 3'd7;
        8: k_draw = 3'd5;
        9: k_draw = 3'd6;
        default: k_draw = 3'($urandom_range(1, 4));
      endcase
      write_reg(CFG_LOG2_POINTS, k_draw);
      write_reg(CFG_INVERSE_MODE, 3'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      n = 1 << ((k_draw < 1) ? 1 : ((k_draw > 6) ? 6 : k_draw));
      frames = (n == 64) ? 1 : $urandom_range(1, 3);
      repeat (frames * n) begin
        push_sample(draw_part(), draw_part());
        sent++;
      end
    end

    in_s.valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
